[rtl/tsc_pkg.sv]
// shared constants and codes for the tsc density grid
`timescale 1ns / 1ps
package tsc_pkg;

    localparam int GRID_SIZE_DEF = 32;

    // field widths
    localparam int CMD_W      = 2;
    localparam int POS_W      = 24;
    localparam int MASS_W     = 24;
    localparam int CELL_W     = 48;
    localparam int WT_W       = 24;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 32;
    localparam int SCALE_W    = 32;

    // datapath widths
    localparam int MUL_A_W = 25;
    localparam int MUL_B_W = 32;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int SUM_W   = 54;
    localparam int ACC_W   = 72;

    // commands
    localparam logic [CMD_W-1:0] CMD_CLEAR   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DEPOSIT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_INTERP  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SCALE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_COUNT = 1'd1;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 32'h0001_0000;
    localparam logic [MASS_W-1:0]  MASS_ONE    = 24'h01_0000;

    // kernel constants: 0.5 and 0.75 in Q0.24
    localparam logic [MUL_A_W-1:0] HALF_Q24 = 25'h080_0000;
    localparam logic [WT_W-1:0]    W0_BASE  = 24'hC0_0000;

endpackage

[rtl/tsc_mass_assign_interp.sv]
// tsc mass assignment and interpolation on a periodic cubic grid
`timescale 1ns / 1ps
// Usage
//   input channel  i_valid / o_ready carries one word: command, position, mass, last
//   output channel o_valid / i_ready carries one word: density, echoed command,
//   saturation flag, echoed last marker
//   config port    i_cfg_we / i_cfg_idx / i_cfg_data writes density_scale (0) or
//   count_mode (1), one per cycle; write only while the block is idle (not enforced)
// Work per word (from acceptance to o_valid)
//   clear            one cell zeroed per cycle until the whole grid is zero
//   deposit          five setup steps per axis, 27 cells of six steps, then output
//   interpolate      same setup, 27 cells of seven steps, four scaling steps, output
//   unused command   goes straight to the output step
//   work is bound by the single shared 25x32 multiplier and the grid memory
//   (one read, one write port), visited by each cell in turn; one word at a time
// Reset
//   a clearing pass zeroes all GRID_SIZE^3 cells (32768 at 32), with
//   o_ready low; config writes are still taken
// Stall
//   a finished word waits in the output register; the next word is accepted
//   meanwhile, and its result waits until the register frees up
module tsc_mass_assign_interp #(
    parameter int GRID_SIZE = tsc_pkg::GRID_SIZE_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [tsc_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [tsc_pkg::CFG_DATA_W-1:0]  i_cfg_data,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [tsc_pkg::CMD_W-1:0]       i_cmd,
    input  logic [tsc_pkg::POS_W-1:0]       i_pos_x,
    input  logic [tsc_pkg::POS_W-1:0]       i_pos_y,
    input  logic [tsc_pkg::POS_W-1:0]       i_pos_z,
    input  logic [tsc_pkg::MASS_W-1:0]      i_mass,
    input  logic                            i_last,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [tsc_pkg::CELL_W-1:0]      o_density,
    output logic [tsc_pkg::CMD_W-1:0]       o_done_cmd,
    output logic                            o_saturated,
    output logic                            o_last_out
);
    import tsc_pkg::*;

    localparam int IW = $clog2(GRID_SIZE);
    localparam int NC = GRID_SIZE * GRID_SIZE * GRID_SIZE;
    localparam int AW = $clog2(NC);
    localparam int RW = POS_W + IW;

    // sequencer states
    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_CLR  = 4'd1;
    localparam logic [3:0] S_AX0  = 4'd2;
    localparam logic [3:0] S_AX1  = 4'd3;
    localparam logic [3:0] S_AX2  = 4'd4;
    localparam logic [3:0] S_AX3  = 4'd5;
    localparam logic [3:0] S_AX4  = 4'd6;
    localparam logic [3:0] S_CELL = 4'd7;
    localparam logic [3:0] S_DN0  = 4'd8;
    localparam logic [3:0] S_DN1  = 4'd9;
    localparam logic [3:0] S_DN2  = 4'd10;
    localparam logic [3:0] S_DN3  = 4'd11;
    localparam logic [3:0] S_OUT  = 4'd12;

    // steps within one cell visit
    localparam logic [2:0] ST_WXY_MUL = 3'd0;
    localparam logic [2:0] ST_WXY_RND = 3'd1;
    localparam logic [2:0] ST_W_MUL   = 3'd2;
    localparam logic [2:0] ST_W_RND   = 3'd3;
    localparam logic [2:0] ST_VAL_MUL = 3'd4;
    localparam logic [2:0] ST_VAL_USE = 3'd5;
    localparam logic [2:0] ST_LO_USE  = 3'd6;

    localparam logic [1:0] AX_X = 2'd0;
    localparam logic [1:0] AX_Y = 2'd1;
    localparam logic [1:0] AX_Z = 2'd2;

    // control
    logic [3:0]    r_state, n_state;
    logic [AW-1:0] r_clr;
    logic          r_has_item;
    logic [1:0]    r_ax;
    logic [2:0]    r_st;
    logic [1:0]    r_ci, r_cj, r_ck;
    logic          r_ovalid;

    // configuration
    logic [SCALE_W-1:0] r_scale;
    logic               r_count;

    // captured word
    logic [CMD_W-1:0]  r_cmd;
    logic [POS_W-1:0]  r_px, r_py, r_pz;
    logic [MASS_W-1:0] r_mass;
    logic              r_last;

    // per-axis indexes and weights
    logic [IW-1:0]   r_ix [3];
    logic [IW-1:0]   r_iy [3];
    logic [IW-1:0]   r_iz [3];
    logic [WT_W-1:0] r_wx [3];
    logic [WT_W-1:0] r_wy [3];
    logic [WT_W-1:0] r_wz [3];
    logic signed [MUL_A_W-1:0] r_h;

    // datapath
    logic [PROD_W-1:0] r_prod;
    logic [WT_W-1:0]   r_wxy, r_w;
    logic [CELL_W-1:0] r_rdata;
    logic [SUM_W-1:0]  r_sum;
    logic [ACC_W-1:0]  r_acc;
    logic              r_sat;

    // output register
    logic [CELL_W-1:0] r_odens;
    logic [CMD_W-1:0]  r_ocmd;
    logic              r_osat;
    logic              r_olast;

    // grid memory
    logic [CELL_W-1:0] r_mem [NC];

    logic              w_accept, w_is_dep, w_cell_end, w_cell_last, w_out_go;
    logic [POS_W-1:0]  w_pos_sel;
    logic [RW-1:0]     w_r;
    logic [IW:0]       w_n;
    logic [IW-1:0]     w_i, w_im, w_ip;
    logic [MUL_A_W-1:0] w_dn, w_up, w_habs;
    logic [MUL_A_W-1:0] w_mul_a;
    logic [MUL_B_W-1:0] w_mul_b;
    logic [PROD_W-1:0]  w_prod;
    logic [47:0]        w_rnd24, w_rnd16;
    logic [49:0]        w_rnd25;
    logic [WT_W-1:0]    w_r24, w_r25;
    logic [31:0]        w_add;
    logic [CELL_W:0]    w_cell_sum;
    logic               w_wt_we;
    logic [1:0]         w_wt_slot;
    logic [WT_W-1:0]    w_wt_val;
    logic [AW-1:0]      w_raddr, w_waddr;
    logic               w_we;
    logic [CELL_W-1:0]  w_wdata;
    logic [MASS_W-1:0]  w_mass_eff;
    logic               w_osat_hi;

    assign w_accept    = i_valid && o_ready;
    assign o_ready     = (r_state == S_IDLE);
    assign w_is_dep    = (r_cmd == CMD_DEPOSIT);
    assign w_cell_end  = (r_state == S_CELL) &&
                         ((w_is_dep && r_st == ST_VAL_USE) || r_st == ST_LO_USE);
    assign w_cell_last = (r_ci == 2'd2) && (r_cj == 2'd2) && (r_ck == 2'd2);
    assign w_out_go    = (r_state == S_OUT) && (!r_ovalid || i_ready);
    assign w_mass_eff  = r_count ? MASS_ONE : r_mass;

    // axis setup: scaled position, nearest cell and offset
    always_comb begin
        unique case (r_ax)
            AX_X:    w_pos_sel = r_px;
            AX_Y:    w_pos_sel = r_py;
            default: w_pos_sel = r_pz;
        endcase
    end

    assign w_r  = RW'(w_pos_sel) * RW'(GRID_SIZE);
    assign w_n  = {1'b0, w_r[RW-1:POS_W]} + (IW+1)'(w_r[POS_W-1]);
    // rounding up to the box edge wraps to cell zero
    assign w_i  = (w_n == (IW+1)'(GRID_SIZE)) ? '0 : w_n[IW-1:0];
    assign w_im = (w_i == '0) ? IW'(GRID_SIZE - 1) : w_i - IW'(1);
    assign w_ip = (w_i == IW'(GRID_SIZE - 1)) ? '0 : w_i + IW'(1);

    assign w_dn   = HALF_Q24 - $unsigned(r_h);
    assign w_up   = HALF_Q24 + $unsigned(r_h);
    assign w_habs = r_h[MUL_A_W-1] ? $unsigned(-r_h) : $unsigned(r_h);

    // rounding of the shared product
    assign w_rnd24 = r_prod[47:0] + 48'h80_0000;
    assign w_rnd25 = r_prod[49:0] + 50'h100_0000;
    assign w_rnd16 = r_prod[47:0] + 48'h8000;
    assign w_r24   = w_rnd24[47:24];
    assign w_r25   = w_rnd25[48:25];
    assign w_add   = w_rnd16[47:16];
    assign w_cell_sum = {1'b0, r_rdata} + (CELL_W+1)'(w_add);

    // shared multiplier operand select
    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        unique case (r_state)
            S_AX1: begin
                w_mul_a = w_dn;
                w_mul_b = MUL_B_W'(w_dn);
            end
            S_AX2: begin
                w_mul_a = w_habs;
                w_mul_b = MUL_B_W'(w_habs);
            end
            S_AX3: begin
                w_mul_a = w_up;
                w_mul_b = MUL_B_W'(w_up);
            end
            S_CELL: begin
                case (r_st)
                    ST_WXY_MUL: begin
                        w_mul_a = MUL_A_W'(r_wx[r_ci]);
                        w_mul_b = MUL_B_W'(r_wy[r_cj]);
                    end
                    ST_W_MUL: begin
                        w_mul_a = MUL_A_W'(r_wxy);
                        w_mul_b = MUL_B_W'(r_wz[r_ck]);
                    end
                    ST_VAL_MUL: begin
                        w_mul_a = MUL_A_W'(r_w);
                        w_mul_b = w_is_dep ? MUL_B_W'(w_mass_eff)
                                           : MUL_B_W'(r_rdata[CELL_W-1:24]);
                    end
                    ST_VAL_USE: begin
                        w_mul_a = MUL_A_W'(r_w);
                        w_mul_b = MUL_B_W'(r_rdata[23:0]);
                    end
                    default: begin
                        w_mul_a = '0;
                        w_mul_b = '0;
                    end
                endcase
            end
            S_DN0: begin
                w_mul_a = MUL_A_W'(r_sum[15:0]);
                w_mul_b = r_scale;
            end
            S_DN1: begin
                w_mul_a = MUL_A_W'(r_sum[39:16]);
                w_mul_b = r_scale;
            end
            S_DN2: begin
                w_mul_a = MUL_A_W'(r_sum[SUM_W-1:40]);
                w_mul_b = r_scale;
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_prod = w_mul_a * w_mul_b;

    // weight write-back during axis setup: lower, centre, upper
    always_comb begin
        w_wt_we   = 1'b0;
        w_wt_slot = 2'd0;
        w_wt_val  = w_r25;
        unique case (r_state)
            S_AX2: begin
                w_wt_we   = 1'b1;
                w_wt_slot = 2'd0;
                w_wt_val  = w_r25;
            end
            S_AX3: begin
                w_wt_we   = 1'b1;
                w_wt_slot = 2'd1;
                w_wt_val  = W0_BASE - w_r24;
            end
            S_AX4: begin
                w_wt_we   = 1'b1;
                w_wt_slot = 2'd2;
                w_wt_val  = w_r25;
            end
            default: begin
                w_wt_we = 1'b0;
            end
        endcase
    end

    // grid address of the visited cell, z-major
    assign w_raddr = (AW'(r_iz[r_ck]) * AW'(GRID_SIZE) + AW'(r_iy[r_cj])) * AW'(GRID_SIZE)
                     + AW'(r_ix[r_ci]);

    always_comb begin
        w_we    = 1'b0;
        w_waddr = w_raddr;
        w_wdata = w_cell_sum[CELL_W-1:0];
        if (r_state == S_CLR) begin
            w_we    = 1'b1;
            w_waddr = r_clr;
            w_wdata = '0;
        end else if (w_cell_end && w_is_dep) begin
            w_we    = 1'b1;
            w_wdata = w_cell_sum[CELL_W] ? {CELL_W{1'b1}} : w_cell_sum[CELL_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rdata <= r_mem[w_raddr];
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    unique case (i_cmd) inside
                        CMD_CLEAR:               n_state = S_CLR;
                        CMD_DEPOSIT, CMD_INTERP: n_state = S_AX0;
                        default:                 n_state = S_OUT;
                    endcase
                end
            end
            S_CLR: begin
                if (r_clr == AW'(NC - 1)) begin
                    n_state = r_has_item ? S_OUT : S_IDLE;
                end
            end
            S_AX0: n_state = S_AX1;
            S_AX1: n_state = S_AX2;
            S_AX2: n_state = S_AX3;
            S_AX3: n_state = S_AX4;
            S_AX4: n_state = (r_ax == AX_Z) ? S_CELL : S_AX0;
            S_CELL: begin
                if (w_cell_end && w_cell_last) begin
                    n_state = w_is_dep ? S_OUT : S_DN0;
                end
            end
            S_DN0: n_state = S_DN1;
            S_DN1: n_state = S_DN2;
            S_DN2: n_state = S_DN3;
            S_DN3: n_state = S_OUT;
            S_OUT: begin
                if (w_out_go) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_clr      <= '0;
            r_has_item <= 1'b0;
            r_ax       <= AX_X;
            r_st       <= ST_WXY_MUL;
            r_ci       <= 2'd0;
            r_cj       <= 2'd0;
            r_ck       <= 2'd0;
            r_ovalid   <= 1'b0;
            r_scale    <= SCALE_RESET;
            r_count    <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_SCALE: r_scale <= i_cfg_data[SCALE_W-1:0];
                    REG_COUNT: r_count <= i_cfg_data[0];
                    default:   r_count <= r_count;
                endcase
            end

            if (w_accept) begin
                r_has_item <= 1'b1;
                r_clr      <= '0;
                r_ax       <= AX_X;
                r_st       <= ST_WXY_MUL;
                r_ci       <= 2'd0;
                r_cj       <= 2'd0;
                r_ck       <= 2'd0;
            end

            if (r_state == S_CLR) begin
                r_clr <= r_clr + AW'(1);
            end

            if (r_state == S_AX4) begin
                r_ax <= r_ax + 2'd1;
            end

            // cell walk: x innermost, then y, then z
            if (r_state == S_CELL) begin
                if (w_cell_end) begin
                    r_st <= ST_WXY_MUL;
                    if (r_ci == 2'd2) begin
                        r_ci <= 2'd0;
                        if (r_cj == 2'd2) begin
                            r_cj <= 2'd0;
                            r_ck <= r_ck + 2'd1;
                        end else begin
                            r_cj <= r_cj + 2'd1;
                        end
                    end else begin
                        r_ci <= r_ci + 2'd1;
                    end
                end else begin
                    r_st <= r_st + 3'd1;
                end
            end

            if (w_out_go) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign w_osat_hi = |r_acc[ACC_W-1:CELL_W];

    // datapath registers
    always_ff @(posedge i_clk) begin
        r_prod <= w_prod;

        if (w_accept) begin
            r_cmd  <= i_cmd;
            r_px   <= i_pos_x;
            r_py   <= i_pos_y;
            r_pz   <= i_pos_z;
            r_mass <= i_mass;
            r_last <= i_last;
            r_sum  <= '0;
            r_sat  <= 1'b0;
        end

        if (r_state == S_AX0) begin
            r_h <= $signed({w_r[POS_W-1], w_r[POS_W-1:0]});
            unique case (r_ax)
                AX_X: begin
                    r_ix[0] <= w_im;
                    r_ix[1] <= w_i;
                    r_ix[2] <= w_ip;
                end
                AX_Y: begin
                    r_iy[0] <= w_im;
                    r_iy[1] <= w_i;
                    r_iy[2] <= w_ip;
                end
                default: begin
                    r_iz[0] <= w_im;
                    r_iz[1] <= w_i;
                    r_iz[2] <= w_ip;
                end
            endcase
        end

        if (w_wt_we) begin
            unique case (r_ax)
                AX_X:    r_wx[w_wt_slot] <= w_wt_val;
                AX_Y:    r_wy[w_wt_slot] <= w_wt_val;
                default: r_wz[w_wt_slot] <= w_wt_val;
            endcase
        end

        if (r_state == S_CELL) begin
            case (r_st)
                ST_WXY_RND: r_wxy <= w_r24;
                ST_W_RND:   r_w   <= w_r24;
                ST_VAL_USE: begin
                    if (w_is_dep) begin
                        if (w_cell_sum[CELL_W]) begin
                            r_sat <= 1'b1;
                        end
                    end else begin
                        r_sum <= r_sum + SUM_W'(r_prod[47:0]);
                    end
                end
                ST_LO_USE:  r_sum <= r_sum + SUM_W'(w_r24);
                default:    r_w   <= r_w;
            endcase
        end

        // scaling: low fraction, middle part, high part shifted up
        unique case (r_state)
            S_DN1:   r_acc <= ACC_W'(w_add);
            S_DN2:   r_acc <= r_acc + ACC_W'(r_prod[55:0]);
            S_DN3:   r_acc <= r_acc + (ACC_W'(r_prod[45:0]) << 24);
            default: r_acc <= r_acc;
        endcase

        if (w_out_go) begin
            r_ocmd  <= r_cmd;
            r_olast <= r_last;
            if (r_cmd == CMD_INTERP) begin
                r_odens <= w_osat_hi ? {CELL_W{1'b1}} : r_acc[CELL_W-1:0];
                r_osat  <= w_osat_hi;
            end else begin
                r_odens <= '0;
                r_osat  <= r_sat && w_is_dep;
            end
        end
    end

    assign o_valid     = r_ovalid;
    assign o_density   = r_odens;
    assign o_done_cmd  = r_ocmd;
    assign o_saturated = r_osat;
    assign o_last_out  = r_olast;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input accepted twice in a row");

    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE || r_state == S_OUT) |-> !w_we)
        else $error("grid written outside clear or deposit");

    a_density_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovalid && r_ocmd != CMD_INTERP) |-> (r_odens == '0))
        else $error("nonzero density for a non-interpolate word");

    a_deposit_steps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CELL && r_cmd == CMD_DEPOSIT) |-> (r_st != ST_LO_USE))
        else $error("deposit ran into the gather step");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && r_ovalid && !i_ready) |=> (r_state == S_OUT))
        else $error("result lost while output stalled");

endmodule
